[hdl/ipscr_pkg.sv]
`timescale 1ns / 1ps
// Package for the IP prefix set cover reduction block.
// Holds the table geometry, the entry type and the prefix masking function.
package ipscr_pkg;

	localparam int TABLE_DEPTH = 64;
	localparam int MAX_RESULTS = 64;
	localparam int IDX_W = $clog2(TABLE_DEPTH);
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
	localparam int OUT_CNT_W = $clog2(MAX_RESULTS + 1);
	localparam logic [7:0] V4_MAX_LEN = 8'd32;
	localparam logic [7:0] V6_MAX_LEN = 8'd128;

	typedef struct packed {
		logic        family;
		logic [7:0]  len;
		logic [63:0] hi;
		logic [63:0] lo;
	} entry_t;

	// Saturate a length to the maximum of its family.
	function automatic logic [7:0] clamp_len(input logic fam, input logic [7:0] len);
		logic [7:0] maxl;
		maxl = fam ? V6_MAX_LEN : V4_MAX_LEN;
		return (len > maxl) ? maxl : len;
	endfunction

	// Mask an address to a prefix length; IPv4 lives in the low 32 bits.
	function automatic entry_t mask_prefix(input logic fam, input logic [7:0] len,
			input logic [63:0] hi, input logic [63:0] lo);
		entry_t     e;
		logic [127:0] m;
		logic [127:0] a;
		m = ~(128'h0) << (8'd128 - {1'b0, len[6:0]});
		if (len[7]) begin
			m = ~(128'h0);
		end else if (len == 8'd0) begin
			m = '0;
		end
		e.family = fam;
		e.len    = len;
		if (fam == 1'b0) begin
			a    = {96'h0, lo[31:0]} & (m >> 96);
			e.hi = '0;
			e.lo = a[63:0];
		end else begin
			a    = {hi, lo} & m;
			e.hi = a[127:64];
			e.lo = a[63:0];
		end
		return e;
	endfunction

endpackage

[hdl/ip_prefix_set_cover_reduce.sv]
`timescale 1ns / 1ps
// Top level of the IP prefix set cover reduction block.
// Depends on ipscr_pkg for the entry type and masking.

// Each input beat masks the prefix and scans the stored entries for a duplicate, a table read
// and then a compare per entry, and inserts it if it is new and the table has room. The beat
// marked last then runs an outer scan over the table with an inner scan per entry of nonzero
// length, reading from a single-port memory, and then emits the survivors in insertion order,
// or an empty marker when none survive, holding each result beat while the receiver stalls.
// No new input beat is taken until the block is idle again.
// The table is invalidated by clearing its fill count, so no clearing pass is needed.
module ip_prefix_set_cover_reduce
	import ipscr_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        family,
	input  logic [7:0]  prefix_len,
	input  logic [63:0] addr_hi,
	input  logic [63:0] addr_lo,
	input  logic        load_last,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        out_family,
	output logic [7:0]  out_len,
	output logic [63:0] out_hi,
	output logic [63:0] out_lo,
	output logic        overflow,
	output logic        any_both,
	output logic        set_empty,
	output logic        out_last
);

	typedef enum logic [3:0] {
		ST_IDLE, ST_DUP_RD, ST_DUP_CMP, ST_INSERT,
		ST_OUT_RD, ST_OUT_LAT, ST_IN_RD, ST_IN_CMP, ST_DECIDE,
		ST_EM_RD, ST_EM_LAT, ST_EM_OUT, ST_EMPTY
	} state_t;

	state_t             state_q;
	entry_t             mem [TABLE_DEPTH];
	entry_t             rd_q;
	entry_t             new_q;
	entry_t             cur_q;
	logic [IDX_W-1:0]   addr;
	logic               we;
	logic [CNT_W-1:0]   count_q;
	logic [CNT_W-1:0]   i_q;
	logic [CNT_W-1:0]   j_q;
	logic               last_q;
	logic               ovf_q;
	logic               any4_q;
	logic               any6_q;
	logic               covered_q;
	logic [TABLE_DEPTH-1:0] survive_q;
	logic [OUT_CNT_W-1:0]   nout_q;
	logic               more;
	entry_t             cmask;

	// Single-port table with a registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= new_q;
		end
		rd_q <= mem[addr];
	end

	assign we = (state_q == ST_INSERT) && (count_q < CNT_W'(TABLE_DEPTH));

	// Address mux across scan phases.
	always_comb begin
		addr = i_q[IDX_W-1:0];
		unique case (state_q)
			ST_INSERT: addr = count_q[IDX_W-1:0];
			ST_IN_RD:  addr = j_q[IDX_W-1:0];
			default:   addr = i_q[IDX_W-1:0];
		endcase
	end

	// Outer entry masked to the inner entry's length.
	assign cmask = mask_prefix(cur_q.family, rd_q.len, cur_q.hi, cur_q.lo);

	// Is there a later survivor to emit after i_q.
	always_comb begin
		more = 1'b0;
		for (int k = 0; k < TABLE_DEPTH; k++) begin
			if (CNT_W'(k) > i_q && CNT_W'(k) < count_q && survive_q[k]) begin
				more = 1'b1;
			end
		end
	end

	assign in_stall = (state_q != ST_IDLE);

	// Control sequencer with registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			new_q     <= '0;
			cur_q     <= '0;
			count_q   <= '0;
			ovf_q     <= 1'b0;
			i_q       <= '0;
			j_q       <= '0;
			last_q    <= 1'b0;
			any4_q    <= 1'b0;
			any6_q    <= 1'b0;
			covered_q <= 1'b0;
			survive_q <= '0;
			nout_q    <= '0;
			out_valid <= 1'b0;
			out_family <= 1'b0;
			out_len   <= '0;
			out_hi    <= '0;
			out_lo    <= '0;
			overflow  <= 1'b0;
			any_both  <= 1'b0;
			set_empty <= 1'b0;
			out_last  <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						new_q  <= mask_prefix(family, clamp_len(family, prefix_len),
							addr_hi, addr_lo);
						last_q <= load_last;
						i_q    <= '0;
						state_q <= ST_DUP_RD;
					end
				end
				ST_DUP_RD: begin
					if (i_q >= count_q) begin
						state_q <= ST_INSERT;
					end else begin
						state_q <= ST_DUP_CMP;
					end
				end
				ST_DUP_CMP: begin
					if (rd_q == new_q) begin
						state_q <= ST_OUT_RD;
						i_q     <= '0;
						any4_q  <= 1'b0;
						any6_q  <= 1'b0;
						if (!last_q) begin
							state_q <= ST_IDLE;
						end
					end else begin
						i_q     <= i_q + 1'b1;
						state_q <= ST_DUP_RD;
					end
				end
				ST_INSERT: begin
					if (count_q < CNT_W'(TABLE_DEPTH)) begin
						count_q <= count_q + 1'b1;
					end else begin
						ovf_q <= 1'b1;
					end
					i_q    <= '0;
					any4_q <= 1'b0;
					any6_q <= 1'b0;
					state_q <= last_q ? ST_OUT_RD : ST_IDLE;
				end
				ST_OUT_RD: begin
					if (i_q >= count_q) begin
						i_q <= '0;
						nout_q <= '0;
						state_q <= (survive_q == '0) ? ST_EMPTY : ST_EM_RD;
					end else begin
						state_q <= ST_OUT_LAT;
					end
				end
				ST_OUT_LAT: begin
					cur_q     <= rd_q;
					j_q       <= '0;
					covered_q <= 1'b0;
					if (rd_q.len == 8'd0) begin
						if (rd_q.family) any6_q <= 1'b1; else any4_q <= 1'b1;
						survive_q[i_q[IDX_W-1:0]] <= 1'b1;
						i_q     <= i_q + 1'b1;
						state_q <= ST_OUT_RD;
					end else begin
						state_q <= ST_IN_RD;
					end
				end
				ST_IN_RD: begin
					state_q <= (j_q >= count_q || covered_q) ? ST_DECIDE : ST_IN_CMP;
				end
				ST_IN_CMP: begin
					if (rd_q.family == cur_q.family && rd_q.len < cur_q.len &&
							cmask.hi == rd_q.hi && cmask.lo == rd_q.lo) begin
						covered_q <= 1'b1;
					end
					j_q     <= j_q + 1'b1;
					state_q <= ST_IN_RD;
				end
				ST_DECIDE: begin
					survive_q[i_q[IDX_W-1:0]] <= !covered_q;
					i_q     <= i_q + 1'b1;
					state_q <= ST_OUT_RD;
				end
				ST_EM_RD: begin
					if (survive_q[i_q[IDX_W-1:0]]) begin
						state_q <= ST_EM_LAT;
					end else begin
						i_q <= i_q + 1'b1;
					end
				end
				ST_EM_LAT: begin
					out_valid  <= 1'b1;
					out_family <= rd_q.family;
					out_len    <= rd_q.len;
					out_hi     <= rd_q.hi;
					out_lo     <= rd_q.lo;
					overflow   <= ovf_q;
					any_both   <= any4_q && any6_q;
					set_empty  <= 1'b0;
					out_last   <= !more || (nout_q == OUT_CNT_W'(MAX_RESULTS - 1));
					nout_q     <= nout_q + 1'b1;
					state_q    <= ST_EM_OUT;
				end
				ST_EM_OUT: begin
					if (!out_stall) begin
						out_valid <= 1'b0;
						i_q       <= i_q + 1'b1;
						if (out_last) begin
							count_q   <= '0;
							ovf_q     <= 1'b0;
							survive_q <= '0;
							state_q   <= ST_IDLE;
						end else begin
							state_q <= ST_EM_RD;
						end
					end
				end
				ST_EMPTY: begin
					if (!out_valid) begin
						out_valid  <= 1'b1;
						out_family <= 1'b0;
						out_len    <= '0;
						out_hi     <= '0;
						out_lo     <= '0;
						overflow   <= ovf_q;
						any_both   <= 1'b0;
						set_empty  <= 1'b1;
						out_last   <= 1'b1;
					end else if (!out_stall) begin
						out_valid <= 1'b0;
						count_q   <= '0;
						ovf_q     <= 1'b0;
						state_q   <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// The fill count never exceeds the table depth.
	assert property (@(posedge clk) disable iff (!arst_n) count_q <= CNT_W'(TABLE_DEPTH))
		else $error("fill count beyond table depth");
	// Results appear only in the emit phases.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (state_q == ST_EM_OUT || state_q == ST_EMPTY))
		else $error("result beat outside emit phase");
	// An empty marker is always the last beat.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && set_empty) |-> out_last)
		else $error("empty marker not last");

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// Testbench for the IP prefix set cover reduction block.
// Drives prefix beats, predicts the surviving prefixes and checks every result beat.
// Depends on ipscr_pkg and ip_prefix_set_cover_reduce.
module testbench;
	import ipscr_pkg::*;

	typedef struct packed {
		logic        family;
		logic [7:0]  len;
		logic [63:0] hi;
		logic [63:0] lo;
		logic        overflow;
		logic        any_both;
		logic        set_empty;
		logic        last;
	} survivor_t;

	localparam int WATCHDOG_LIMIT = 200000;

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_stall;
	logic        family;
	logic [7:0]  prefix_len;
	logic [63:0] addr_hi;
	logic [63:0] addr_lo;
	logic        load_last;
	logic        out_valid;
	logic        out_stall;
	logic        out_family;
	logic [7:0]  out_len;
	logic [63:0] out_hi;
	logic [63:0] out_lo;
	logic        overflow;
	logic        any_both;
	logic        set_empty;
	logic        out_last;

	// Predictor state: the prefix table as the block should hold it.
	entry_t    pfx_table[$];
	logic      pfx_dropped;
	survivor_t expected_survivors[$];
	int        fail_count;
	int        idle_pct;
	int        stall_cycles;

	ip_prefix_set_cover_reduce dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.family(family), .prefix_len(prefix_len), .addr_hi(addr_hi), .addr_lo(addr_lo),
		.load_last(load_last),
		.out_valid(out_valid), .out_stall(out_stall),
		.out_family(out_family), .out_len(out_len), .out_hi(out_hi), .out_lo(out_lo),
		.overflow(overflow), .any_both(any_both), .set_empty(set_empty), .out_last(out_last)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Mask an address to its prefix length, IPv4 in the low 32 bits.
	function automatic entry_t masked_prefix(logic fam, logic [7:0] len, logic [63:0] hi,
			logic [63:0] lo);
		entry_t       e;
		logic [127:0] keep;
		keep = (len == 0) ? 128'h0 : ~(128'h0) << (128 - len);
		e.family = fam;
		e.len    = len;
		if (!fam) begin
			e.hi = '0;
			e.lo = {32'h0, lo[31:0] & keep[127:96]};
		end else begin
			{e.hi, e.lo} = {hi, lo} & keep;
		end
		return e;
	endfunction

	// Insert one prefix; on the last beat, work out the survivors and clear the set.
	task automatic predict_prefix(logic fam, logic [7:0] len_in, logic [63:0] hi,
			logic [63:0] lo, logic last);
		entry_t    e;
		entry_t    c;
		logic [7:0] len;
		logic      dup;
		logic      v4_all;
		logic      v6_all;
		logic      kept;
		survivor_t s;
		int        n;
		len = fam ? ((len_in > 128) ? 8'd128 : len_in) : ((len_in > 32) ? 8'd32 : len_in);
		e = masked_prefix(fam, len, hi, lo);
		dup = 1'b0;
		foreach (pfx_table[i])
			if (pfx_table[i] == e)
				dup = 1'b1;
		if (!dup) begin
			if (pfx_table.size() < TABLE_DEPTH)
				pfx_table.push_back(e);
			else
				pfx_dropped = 1'b1;
		end
		if (!last)
			return;
		v4_all = 1'b0;
		v6_all = 1'b0;
		foreach (pfx_table[i])
			if (pfx_table[i].len == 0) begin
				if (pfx_table[i].family)
					v6_all = 1'b1;
				else
					v4_all = 1'b1;
			end
		n = 0;
		foreach (pfx_table[i]) begin
			kept = 1'b1;
			if (pfx_table[i].len != 0)
				foreach (pfx_table[j]) begin
					if (pfx_table[j].family != pfx_table[i].family ||
							pfx_table[j].len >= pfx_table[i].len)
						continue;
					c = masked_prefix(pfx_table[i].family, pfx_table[j].len,
						pfx_table[i].hi, pfx_table[i].lo);
					if (c.hi == pfx_table[j].hi && c.lo == pfx_table[j].lo)
						kept = 1'b0;
				end
			if (kept) begin
				s = '{pfx_table[i].family, pfx_table[i].len, pfx_table[i].hi,
					pfx_table[i].lo, pfx_dropped, v4_all & v6_all, 1'b0, 1'b0};
				expected_survivors.push_back(s);
				n++;
			end
		end
		if (n == 0)
			expected_survivors.push_back('{1'b0, 8'd0, 64'd0, 64'd0, pfx_dropped, 1'b0,
				1'b1, 1'b1});
		else
			expected_survivors[$].last = 1'b1;
		pfx_table.delete();
		pfx_dropped = 1'b0;
	endtask

	task automatic report_mismatch(string what);
		$display("mismatch: %s at %0t", what, $realtime);
		fail_count++;
	endtask

	// Send one prefix beat, with a random gap before it.
	task automatic send_prefix(logic fam, logic [7:0] len, logic [63:0] hi, logic [63:0] lo,
			logic last);
		while ($urandom_range(99) < idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid   <= 1'b1;
		family     <= fam;
		prefix_len <= len;
		addr_hi    <= hi;
		addr_lo    <= lo;
		load_last  <= last;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		predict_prefix(fam, len, hi, lo, last);
		@(negedge clk);
		in_valid <= 1'b0;
		// The block is still busy with the beat here, so this wait costs no throughput.
		@(negedge clk);
	endtask

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Random prefix, sometimes derived from a base so that covering happens often.
	task automatic send_random_prefix(logic last, logic [63:0] base_hi, logic [63:0] base_lo);
		logic       fam;
		logic [7:0] len;
		logic [63:0] hi;
		logic [63:0] lo;
		fam = 1'($urandom_range(1));
		len = ($urandom_range(9) == 0) ? 8'($urandom()) :
			(fam ? 8'($urandom_range(128)) : 8'($urandom_range(32)));
		hi = rand64();
		lo = rand64();
		if ($urandom_range(2) != 0) begin
			hi = base_hi ^ (rand64() & (64'h1 << $urandom_range(63)));
			lo = base_lo ^ (rand64() & (64'h1 << $urandom_range(63)));
		end
		send_prefix(fam, len, hi, lo, last);
	endtask

	task automatic wait_drained();
		while (expected_survivors.size() != 0)
			@(negedge clk);
		repeat (10) @(negedge clk);
	endtask

	// Directed: extremes of length and address, duplicates, covering and both /0 entries.
	task automatic test_directed();
		send_prefix(1'b0, 8'd0, 64'd0, 64'd0, 1'b1);
		send_prefix(1'b0, 8'd24, '1, 64'h0000_0000_c0a8_0101, 1'b0);
		send_prefix(1'b0, 8'd24, '1, 64'hffff_ffff_c0a8_01ff, 1'b0);
		send_prefix(1'b0, 8'd16, 64'd0, 64'h0000_0000_c0a8_0000, 1'b0);
		send_prefix(1'b0, 8'd255, 64'd0, '1, 1'b0);
		send_prefix(1'b1, 8'd200, '1, '1, 1'b0);
		send_prefix(1'b1, 8'd64, '1, '1, 1'b0);
		send_prefix(1'b1, 8'd1, 64'h8000_0000_0000_0000, 64'd0, 1'b0);
		send_prefix(1'b1, 8'd65, 64'h1234, '1, 1'b0);
		send_prefix(1'b1, 8'd127, 64'h5555, 64'haaaa, 1'b1);
		send_prefix(1'b0, 8'd0, '1, '1, 1'b0);
		send_prefix(1'b1, 8'd0, '1, '1, 1'b0);
		send_prefix(1'b0, 8'd32, 64'd0, 64'h0a00_0001, 1'b0);
		send_prefix(1'b1, 8'd128, '1, 64'd1, 1'b1);
		send_prefix(1'b0, 8'd33, 64'd0, 64'h1, 1'b1);
		wait_drained();
	endtask

	// Overflow: more distinct prefixes than the table holds.
	task automatic test_overflow();
		for (int i = 0; i < TABLE_DEPTH + 3; i++)
			send_prefix(1'b1, 8'd128, 64'd0, 64'(i), i == TABLE_DEPTH + 2);
		send_prefix(1'b1, 8'd128, 64'd0, 64'd7, 1'b1);
	endtask

	// Random sets of mostly small size.
	task automatic test_random_sets();
		logic [63:0] base_hi;
		logic [63:0] base_lo;
		int          sent;
		int          set_len;
		sent = 0;
		while (sent < 97) begin
			idle_pct = (sent < 40) ? 0 : 19;
			base_hi = rand64();
			base_lo = rand64();
			set_len = $urandom_range(12, 1);
			for (int k = 0; k < set_len; k++)
				send_random_prefix(k == set_len - 1, base_hi, base_lo);
			sent += set_len;
			if (sent > 90 && sent < 110)
				wait_drained();
		end
		wait_drained();
	endtask

	// Receiver stall, off for the early stretch.
	always @(negedge clk)
		out_stall <= (stall_cycles > 0 && $urandom_range(99) < 19);

	// Check each result beat against the oldest expected survivor.
	always @(posedge clk) begin
		survivor_t got;
		survivor_t exp_s;
		stall_cycles <= stall_cycles + 1;
		if (out_valid && !out_stall) begin
			got = '{out_family, out_len, out_hi, out_lo, overflow, any_both, set_empty,
				out_last};
			if (expected_survivors.size() == 0) begin
				report_mismatch("result beat with nothing expected");
			end else begin
				exp_s = expected_survivors.pop_front();
				if (got.family !== exp_s.family) report_mismatch("out_family");
				if (got.len !== exp_s.len) report_mismatch("out_len");
				if (got.hi !== exp_s.hi) report_mismatch("out_hi");
				if (got.lo !== exp_s.lo) report_mismatch("out_lo");
				if (got.overflow !== exp_s.overflow) report_mismatch("overflow");
				if (got.any_both !== exp_s.any_both) report_mismatch("any_both");
				if (got.set_empty !== exp_s.set_empty) report_mismatch("set_empty");
				if (got.last !== exp_s.last) report_mismatch("out_last");
			end
		end
	end

	// Watchdog on cycles with no accepted beat.
	int quiet_cycles;
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || !arst_n)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		family = 1'b0;
		prefix_len = '0;
		addr_hi = '0;
		addr_lo = '0;
		load_last = 1'b0;
		out_stall = 1'b0;
		fail_count = 0;
		idle_pct = 0;
		stall_cycles = -3000;
		quiet_cycles = 0;
		pfx_dropped = 1'b0;
		repeat (12) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		idle_pct = 19;
		test_overflow();
		test_random_sets();
		if (expected_survivors.size() != 0)
			report_mismatch("expected results left over");
		if (fail_count == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
